[sv/affine_texture_sample_blend_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the affine texture sample blend block
// Clocked concurrent assertion forms, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TEXTURE_SAMPLE_BLEND_TOP_ASSERT_SVH
`define AFFINE_TEXTURE_SAMPLE_BLEND_TOP_ASSERT_SVH

// assertion that is off while reset is high
`define ATSB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that also holds across reset
`define ATSB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/atsb_pkg.sv]
// ----------------------------------------------------------------------------
// atsb_pkg
// Types, codes and helpers shared by the affine texture sample blend block.
// ----------------------------------------------------------------------------
package atsb_pkg;

   localparam int PixelBits   = 9;
   localparam int IndexBits   = 10;
   localparam int FracBits    = 16;
   localparam int AddrMaxBits = 16;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   typedef enum logic [2:0] {
      CSR_COEF_XX    = 3'd0,
      CSR_COEF_XY    = 3'd1,
      CSR_COEF_YX    = 3'd2,
      CSR_COEF_YY    = 3'd3,
      CSR_OFFSET_ROW = 3'd4,
      CSR_OFFSET_COL = 3'd5,
      CSR_BG_BLUE    = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_HIT  = 2'd1,
      OP_MISS = 2'd2
   } op_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } texel_type;

   typedef struct packed {
      logic signed [31:0] coef_xx;
      logic signed [31:0] coef_xy;
      logic signed [31:0] coef_yx;
      logic signed [31:0] coef_yy;
      logic signed [31:0] offset_row;
      logic signed [31:0] offset_col;
      logic [7:0]         background_blue;
   } cfg_type;

   typedef struct packed {
      op_type                 op;
      logic [AddrMaxBits-1:0] addr;
      texel_type              texel;
   } entry_type;

   // floor(p / 255) for p <= 255*255
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] t;
      t = 17'(p) + 17'd1 + 17'(p[15:8]);
      return t[15:8];
   endfunction

endpackage

[sv/atsb_fifo.sv]
// ----------------------------------------------------------------------------
// atsb_fifo
// Short request queue between the front and back halves.
// ----------------------------------------------------------------------------
module atsb_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic             full
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CntW'(DEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/atsb_front.sv]
// ----------------------------------------------------------------------------
// atsb_front
// Accepts requests, maps pixels through the affine transform, classifies
// each request as load, hit or miss and forms the texture address.
// ----------------------------------------------------------------------------
module atsb_front #(
   parameter int TEX_SIZE   = 32,
   parameter int COORD_BITS = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  atsb_pkg::cfg_type                   cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic                                in_func,
   input  logic [atsb_pkg::IndexBits-1:0]      in_index,
   input  atsb_pkg::texel_type                 in_texel,
   input  logic [atsb_pkg::PixelBits-1:0]      in_x,
   input  logic [atsb_pkg::PixelBits-1:0]      in_y,
   input  logic                                q_full,
   output logic                                push_valid,
   output atsb_pkg::entry_type                 push_entry
);

   localparam int XB = (COORD_BITS < atsb_pkg::PixelBits) ? COORD_BITS
                                                          : atsb_pkg::PixelBits;
   localparam int PW       = XB + 33;
   localparam int SW       = PW + 2;
   localparam int FB       = atsb_pkg::FracBits;
   localparam int RCW      = $clog2(TEX_SIZE);
   localparam int TexDepth = TEX_SIZE * TEX_SIZE;
   localparam int AW       = $clog2(TexDepth);

   logic adv;

   // stage 1: products
   logic signed [XB:0]              x_s, y_s;
   logic signed [PW-1:0]            p_xx_in, p_xy_in, p_yx_in, p_yy_in;
   logic signed [PW-1:0]            p_xx_ff, p_xy_ff, p_yx_ff, p_yy_ff;
   logic                            f1_valid_ff;
   logic                            f1_load_ff, f1_load_in;
   logic [atsb_pkg::IndexBits-1:0]  f1_index_ff;
   atsb_pkg::texel_type             f1_texel_ff;

   // stage 2: sums and range check
   logic signed [SW-1:0]            row_s, col_s;
   logic                            row_hit, col_hit, idx_ok;
   logic                            f2_valid_ff, f2_valid_in;
   atsb_pkg::op_type                f2_op_ff, f2_op_in;
   logic [RCW-1:0]                  f2_row_ff, f2_col_ff;
   logic [atsb_pkg::IndexBits-1:0]  f2_index_ff;
   atsb_pkg::texel_type             f2_texel_ff;

   // stage 3: address
   logic [AW-1:0]                   addr_in;
   logic                            f3_valid_ff;
   atsb_pkg::entry_type             f3_entry_ff, f3_entry_in;

   assign adv      = !f3_valid_ff || !q_full;
   assign in_ready = adv;

   assign x_s        = $signed({1'b0, in_x[XB-1:0]});
   assign y_s        = $signed({1'b0, in_y[XB-1:0]});
   assign p_xx_in    = x_s * cfg.coef_xx;
   assign p_xy_in    = x_s * cfg.coef_xy;
   assign p_yx_in    = y_s * cfg.coef_yx;
   assign p_yy_in    = y_s * cfg.coef_yy;
   assign f1_load_in = (in_func == atsb_pkg::FUNC_LOAD);

   assign row_s   = SW'(p_xx_ff) + SW'(p_yx_ff) + SW'(cfg.offset_row);
   assign col_s   = SW'(p_xy_ff) + SW'(p_yy_ff) + SW'(cfg.offset_col);
   assign row_hit = !row_s[SW-1] && (row_s[SW-2:FB] < (SW-1-FB)'(TEX_SIZE));
   assign col_hit = !col_s[SW-1] && (col_s[SW-2:FB] < (SW-1-FB)'(TEX_SIZE));
   assign idx_ok  = (32'(f1_index_ff) < 32'(TexDepth));

   always_comb begin
      f2_valid_in = f1_valid_ff && (!f1_load_ff || idx_ok);
      if (f1_load_ff) begin
         f2_op_in = atsb_pkg::OP_LOAD;
      end else if (row_hit && col_hit) begin
         f2_op_in = atsb_pkg::OP_HIT;
      end else begin
         f2_op_in = atsb_pkg::OP_MISS;
      end
   end

   always_comb begin
      if (f2_op_ff == atsb_pkg::OP_LOAD) begin
         addr_in = AW'(f2_index_ff);
      end else begin
         addr_in = AW'(f2_row_ff) * AW'(TEX_SIZE) + AW'(f2_col_ff);
      end
      f3_entry_in.op    = f2_op_ff;
      f3_entry_in.addr  = atsb_pkg::AddrMaxBits'(addr_in);
      f3_entry_in.texel = f2_texel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= in_valid;
         f2_valid_ff <= f2_valid_in;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_xx_ff     <= p_xx_in;
         p_xy_ff     <= p_xy_in;
         p_yx_ff     <= p_yx_in;
         p_yy_ff     <= p_yy_in;
         f1_load_ff  <= f1_load_in;
         f1_index_ff <= in_index;
         f1_texel_ff <= in_texel;
         f2_op_ff    <= f2_op_in;
         f2_row_ff   <= row_s[FB +: RCW];
         f2_col_ff   <= col_s[FB +: RCW];
         f2_index_ff <= f1_index_ff;
         f2_texel_ff <= f1_texel_ff;
         f3_entry_ff <= f3_entry_in;
      end
   end

   assign push_valid = f3_valid_ff && !q_full;
   assign push_entry = f3_entry_ff;

endmodule

[sv/atsb_back.sv]
// ----------------------------------------------------------------------------
// atsb_back
// Texture store, texel fetch and alpha blend over the blue background.
// ----------------------------------------------------------------------------
module atsb_back #(
   parameter int TEX_SIZE = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          bg_blue,
   input  logic                q_valid,
   input  atsb_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic                rsp_hit
);

   localparam int TexDepth = TEX_SIZE * TEX_SIZE;
   localparam int AW       = $clog2(TexDepth);

   atsb_pkg::texel_type tex_mem [TexDepth];

   logic                adv, pop;
   logic [AW-1:0]       addr;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_hit_ff;
   atsb_pkg::texel_type s1_texel_ff;

   logic                s2_valid_ff;
   logic                s2_hit_ff;
   logic [15:0]         pr_in, pg_in, pb_in, pk_in;
   logic [15:0]         pr_ff, pg_ff, pb_ff, pk_ff;

   logic                o_valid_ff;
   logic [7:0]          o_red_ff, o_red_in;
   logic [7:0]          o_green_ff, o_green_in;
   logic [7:0]          o_blue_ff, o_blue_in;
   logic                o_hit_ff;
   logic [8:0]          blue_sum;

   assign adv         = !o_valid_ff || rsp_ready;
   assign pop         = q_valid && adv;
   assign q_pop       = adv;
   assign addr        = q_entry.addr[AW-1:0];
   assign s1_valid_in = pop && (q_entry.op != atsb_pkg::OP_LOAD);

   always_ff @(posedge clock) begin
      if (pop && (q_entry.op == atsb_pkg::OP_LOAD)) begin
         tex_mem[addr] <= q_entry.texel;
      end
      if (pop && (q_entry.op == atsb_pkg::OP_HIT)) begin
         s1_texel_ff <= tex_mem[addr];
      end
   end

   assign pr_in = 16'(s1_texel_ff.alpha) * 16'(s1_texel_ff.red);
   assign pg_in = 16'(s1_texel_ff.alpha) * 16'(s1_texel_ff.green);
   assign pb_in = 16'(s1_texel_ff.alpha) * 16'(s1_texel_ff.blue);
   assign pk_in = 16'(8'd255 - s1_texel_ff.alpha) * 16'(bg_blue);

   always_comb begin
      blue_sum = 9'(atsb_pkg::div255(pb_ff)) + 9'(atsb_pkg::div255(pk_ff));
      if (s2_hit_ff) begin
         o_red_in   = atsb_pkg::div255(pr_ff);
         o_green_in = atsb_pkg::div255(pg_ff);
         o_blue_in  = blue_sum[7:0];
      end else begin
         o_red_in   = 8'd0;
         o_green_in = 8'd0;
         o_blue_in  = bg_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         o_valid_ff  <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_hit_ff  <= (q_entry.op == atsb_pkg::OP_HIT);
         s2_hit_ff  <= s1_hit_ff;
         pr_ff      <= pr_in;
         pg_ff      <= pg_in;
         pb_ff      <= pb_in;
         pk_ff      <= pk_in;
         o_hit_ff   <= s2_hit_ff;
         o_red_ff   <= o_red_in;
         o_green_ff <= o_green_in;
         o_blue_ff  <= o_blue_in;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_red   = o_red_ff;
   assign rsp_green = o_green_ff;
   assign rsp_blue  = o_blue_ff;
   assign rsp_hit   = o_hit_ff;

endmodule

[sv/affine_texture_sample_blend_top.sv]
// ----------------------------------------------------------------------------
// affine_texture_sample_blend_top
// Inverse affine texture mapper with nearest texel sampling and alpha blend.
//
// Requests enter on req_*. tuser selects the kind: a load writes one RGBA
// texel into the texture store and yields no response; a pixel request maps
// (x, y) through the Q16.16 transform and yields one response on rsp_*
// (blended color in tdata, hit flag in tuser), in request order.
// Registers are to be written on csr_* only while the block is idle; the
// user must keep to this, as the block does not enforce it. Throughput: one
// request per cycle unless responses stall, set by the single texture store
// port that a load write or a pixel fetch uses once per queue pop. A pixel
// passes 3 front stages, the queue, memory read, multiply, output register.
// A 4-entry queue splits the front (transform, classify) from the back
// (store, blend); when rsp_tready is low the back holds its output and the
// queue fills, and only then does req_tready drop.
// Reset clears pipeline valids, the queue and the registers to their
// defaults; the texture store has no reset and must be loaded before use.
// ----------------------------------------------------------------------------
module affine_texture_sample_blend_top #(
   parameter int TEX_SIZE   = 32,
   parameter int COORD_BITS = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // texel_index[9:0], texel_red, texel_green, texel_blue, texel_alpha,
   // pixel_x[8:0], pixel_y[8:0], zero fill
   input  logic [63:0] req_tdata,
   // func
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red, out_green, out_blue, zero fill
   output logic [31:0] rsp_tdata,
   // hit_texture
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int QDepth = 4;
   localparam int QWidth = $bits(atsb_pkg::entry_type);

   atsb_pkg::cfg_type   cfg_ff;
   atsb_pkg::texel_type req_texel;
   atsb_pkg::entry_type push_entry, pop_entry;
   logic [QWidth-1:0]   pop_data;
   logic                push_valid, q_full, q_valid, q_pop;
   logic [7:0]          out_red, out_green, out_blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_xx         <= 32'sd65536;
         cfg_ff.coef_xy         <= 32'sd0;
         cfg_ff.coef_yx         <= 32'sd0;
         cfg_ff.coef_yy         <= 32'sd65536;
         cfg_ff.offset_row      <= 32'sd0;
         cfg_ff.offset_col      <= 32'sd0;
         cfg_ff.background_blue <= 8'd55;
      end else if (csr_we) begin
         unique case (csr_index)
            atsb_pkg::CSR_COEF_XX:    cfg_ff.coef_xx         <= csr_wdata;
            atsb_pkg::CSR_COEF_XY:    cfg_ff.coef_xy         <= csr_wdata;
            atsb_pkg::CSR_COEF_YX:    cfg_ff.coef_yx         <= csr_wdata;
            atsb_pkg::CSR_COEF_YY:    cfg_ff.coef_yy         <= csr_wdata;
            atsb_pkg::CSR_OFFSET_ROW: cfg_ff.offset_row      <= csr_wdata;
            atsb_pkg::CSR_OFFSET_COL: cfg_ff.offset_col      <= csr_wdata;
            atsb_pkg::CSR_BG_BLUE:    cfg_ff.background_blue <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   assign req_texel.red   = req_tdata[17:10];
   assign req_texel.green = req_tdata[25:18];
   assign req_texel.blue  = req_tdata[33:26];
   assign req_texel.alpha = req_tdata[41:34];

   atsb_front #(
      .TEX_SIZE   (TEX_SIZE),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_func    (req_tuser),
      .in_index   (req_tdata[9:0]),
      .in_texel   (req_texel),
      .in_x       (req_tdata[50:42]),
      .in_y       (req_tdata[59:51]),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   atsb_fifo #(
      .DEPTH (QDepth),
      .WIDTH (QWidth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_entry),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .not_empty (q_valid),
      .full      (q_full)
   );

   assign pop_entry = atsb_pkg::entry_type'(pop_data);

   atsb_back #(
      .TEX_SIZE (TEX_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .bg_blue   (cfg_ff.background_blue),
      .q_valid   (q_valid),
      .q_entry   (pop_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_red   (out_red),
      .rsp_green (out_green),
      .rsp_blue  (out_blue),
      .rsp_hit   (rsp_tuser)
   );

   assign rsp_tdata = {8'd0, out_blue, out_green, out_red};

endmodule

[sv/atsb_checker.sv]
// ----------------------------------------------------------------------------
// atsb_checker
// Port-level checks for the affine texture sample blend block.
// ----------------------------------------------------------------------------
`include "affine_texture_sample_blend_top_assert.svh"

module atsb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   `ATSB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")
   `ATSB_ASSERT(a_miss_black, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:0] == 16'd0, "miss response with red or green set")
   `ATSB_ASSERT_ALWAYS(a_reset_rsp, clock, reset |=> !rsp_tvalid, "response valid after reset")
   `ATSB_ASSERT_ALWAYS(a_reset_ready, clock, reset |=> req_tready, "request not ready after reset")

endmodule

bind affine_texture_sample_blend_top atsb_checker u_atsb_checker (.*);
